[src/tdpe_pkg.sv]
`default_nettype none

package tdpe_pkg;

  // Top three opcode bits of the supported formats.
  localparam logic [2:0] FMT_SHIFT_ADDSUB = 3'b000;
  localparam logic [2:0] FMT_IMM8         = 3'b001;
  // Top six opcode bits of the register ALU format.
  localparam logic [5:0] FMT_ALU_PREFIX   = 6'b010000;

  // Sub-operation field of the shift / add-subtract format.
  localparam logic [1:0] SUB_ADDSUB = 2'b11;

  // Operations of the 8-bit immediate format.
  localparam logic [1:0] IMM_MOV = 2'b00;
  localparam logic [1:0] IMM_CMP = 2'b01;
  localparam logic [1:0] IMM_ADD = 2'b10;
  localparam logic [1:0] IMM_SUB = 2'b11;

  typedef enum logic [1:0] {
    SH_LSL = 2'b00,
    SH_LSR = 2'b01,
    SH_ASR = 2'b10,
    SH_ROR = 2'b11
  } tdpe_shift_t;

  typedef enum logic [3:0] {
    ALU_AND = 4'h0,
    ALU_EOR = 4'h1,
    ALU_LSL = 4'h2,
    ALU_LSR = 4'h3,
    ALU_ASR = 4'h4,
    ALU_ADC = 4'h5,
    ALU_SBC = 4'h6,
    ALU_ROR = 4'h7,
    ALU_TST = 4'h8,
    ALU_NEG = 4'h9,
    ALU_CMP = 4'hA,
    ALU_CMN = 4'hB,
    ALU_ORR = 4'hC,
    ALU_MUL = 4'hD,
    ALU_BIC = 4'hE,
    ALU_MVN = 4'hF
  } tdpe_alu_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  dest;
    logic        write;
    logic [3:0]  flags;
    logic        unsup;
  } tdpe_exec_t;

endpackage

`default_nettype wire

[src/tdpe_regfile.sv]
`default_nettype none

module tdpe_regfile
  import tdpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        re,
  input  wire logic [2:0]  raddr_a,
  input  wire logic [2:0]  raddr_b,
  output logic      [31:0] rdata_a,
  output logic      [31:0] rdata_b,
  input  wire logic        we,
  input  wire logic [2:0]  waddr,
  input  wire logic [31:0] wdata
);

  logic [31:0] mem [8];
  logic [7:0]  vld;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads with write-through, so a word captured in the same
  // cycle as the write of its source register sees the new value.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr_a)) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= vld[raddr_a] ? mem[raddr_a] : '0;
      end
      if (we && (waddr == raddr_b)) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= vld[raddr_b] ? mem[raddr_b] : '0;
      end
    end
  end

endmodule

`default_nettype wire

[src/tdpe_shifter.sv]
`default_nettype none

module tdpe_shifter
  import tdpe_pkg::*;
(
  input  wire logic [31:0] value,
  input  wire tdpe_shift_t kind,
  input  wire logic [7:0]  amount,
  input  wire logic        by_imm,
  input  wire logic        cin,
  output logic      [31:0] result,
  output logic             cout
);

  logic [7:0]  amt;
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic [32:0] asr_ext;
  logic [63:0] ror_ext;
  logic        sign;

  // An immediate LSR or ASR of zero encodes a shift by 32.
  assign amt = (by_imm && (amount == 8'd0) && ((kind == SH_LSR) || (kind == SH_ASR)))
               ? 8'd32 : amount;

  assign sign    = value[31];
  assign lsl_ext = {1'b0, value} << amt[4:0];
  assign lsr_ext = {value, 1'b0} >> amt[4:0];
  assign asr_ext = 33'($signed({value, 1'b0}) >>> amt[4:0]);
  assign ror_ext = {value, value} >> amt[4:0];

  always_comb begin
    result = value;
    cout   = cin;
    if (amt != 8'd0) begin
      case (kind)
        SH_LSL: begin
          if (amt < 8'd32) begin
            result = lsl_ext[31:0];
            cout   = lsl_ext[32];
          end else begin
            result = '0;
            cout   = (amt == 8'd32) ? value[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (amt < 8'd32) begin
            result = lsr_ext[32:1];
            cout   = lsr_ext[0];
          end else begin
            result = '0;
            cout   = (amt == 8'd32) ? sign : 1'b0;
          end
        end
        SH_ASR: begin
          if (amt < 8'd32) begin
            result = asr_ext[32:1];
            cout   = asr_ext[0];
          end else begin
            result = {32{sign}};
            cout   = sign;
          end
        end
        SH_ROR: begin
          // A rotation by a multiple of 32 leaves the value and copies bit 31.
          result = ror_ext[31:0];
          cout   = ror_ext[31];
        end
        default: begin
          result = value;
          cout   = cin;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/tdpe_alu.sv]
`default_nettype none

module tdpe_alu
  import tdpe_pkg::*;
(
  input  wire logic [15:0] instr,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  input  wire logic [3:0]  flags_in,
  output tdpe_exec_t       ex
);

  logic         is_fmt0;
  logic         is_fmt1;
  logic         is_alu;
  tdpe_alu_op_t op;
  logic [1:0]   imm_op;
  logic [31:0]  imm8;
  logic [31:0]  b_fmt0;

  logic [31:0]  add_x;
  logic [31:0]  add_y;
  logic         add_c;
  logic [32:0]  sum;
  logic [3:0]   add_flags;

  tdpe_shift_t  sh_kind;
  logic [7:0]   sh_amount;
  logic [31:0]  sh_result;
  logic         sh_cout;
  logic [31:0]  mul_result;

  assign is_fmt0 = (instr[15:13] == FMT_SHIFT_ADDSUB);
  assign is_fmt1 = (instr[15:13] == FMT_IMM8);
  assign is_alu  = (instr[15:10] == FMT_ALU_PREFIX);
  assign op      = tdpe_alu_op_t'(instr[9:6]);
  assign imm_op  = instr[12:11];
  assign imm8    = {24'd0, instr[7:0]};
  assign b_fmt0  = instr[10] ? {29'd0, instr[8:6]} : op_b;

  // Adder operand selection.
  always_comb begin
    add_x = op_a;
    add_y = op_b;
    add_c = 1'b0;
    if (is_fmt0) begin
      add_y = instr[9] ? ~b_fmt0 : b_fmt0;
      add_c = instr[9];
    end else if (is_fmt1) begin
      add_y = (imm_op == IMM_ADD) ? imm8 : ~imm8;
      add_c = (imm_op != IMM_ADD);
    end else begin
      case (op)
        ALU_ADC: begin
          add_c = flags_in[1];
        end
        ALU_SBC: begin
          add_y = ~op_b;
          add_c = flags_in[1];
        end
        ALU_NEG: begin
          add_x = '0;
          add_y = ~op_b;
          add_c = 1'b1;
        end
        ALU_CMP: begin
          add_y = ~op_b;
          add_c = 1'b1;
        end
        default: begin
          add_c = 1'b0;
        end
      endcase
    end
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};
  assign add_flags = {sum[31], (sum[31:0] == 32'd0), sum[32],
                      ((add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]))};

  // Shared barrel shifter: immediate shifts and register shifts both shift op_a.
  always_comb begin
    if (is_fmt0) begin
      sh_kind   = tdpe_shift_t'(instr[12:11]);
      sh_amount = {3'd0, instr[10:6]};
    end else begin
      sh_kind   = (op == ALU_ROR) ? SH_ROR : tdpe_shift_t'(2'(instr[9:6] - 4'd2));
      sh_amount = op_b[7:0];
    end
  end

  tdpe_shifter u_shifter (
    .value  (op_a),
    .kind   (sh_kind),
    .amount (sh_amount),
    .by_imm (is_fmt0),
    .cin    (flags_in[1]),
    .result (sh_result),
    .cout   (sh_cout)
  );

  assign mul_result = op_a * op_b;

  function automatic logic [3:0] nz_flags(input logic [31:0] r, input logic [3:0] old);
    nz_flags = {r[31], (r == 32'd0), old[1:0]};
  endfunction

  always_comb begin
    ex.value = '0;
    ex.dest  = '0;
    ex.write = 1'b0;
    ex.flags = flags_in;
    ex.unsup = 1'b0;
    if (is_fmt0) begin
      ex.dest  = instr[2:0];
      ex.write = 1'b1;
      if (instr[12:11] == SUB_ADDSUB) begin
        ex.value = sum[31:0];
        ex.flags = add_flags;
      end else begin
        ex.value = sh_result;
        ex.flags = {sh_result[31], (sh_result == 32'd0), sh_cout, flags_in[0]};
      end
    end else if (is_fmt1) begin
      ex.dest  = instr[10:8];
      ex.write = (imm_op != IMM_CMP);
      if (imm_op == IMM_MOV) begin
        ex.value = imm8;
        ex.flags = nz_flags(imm8, flags_in);
      end else begin
        ex.value = sum[31:0];
        ex.flags = add_flags;
      end
    end else if (is_alu) begin
      ex.dest  = instr[2:0];
      ex.write = 1'b1;
      case (op)
        ALU_AND, ALU_TST: begin
          ex.value = op_a & op_b;
          ex.write = (op == ALU_AND);
        end
        ALU_EOR: ex.value = op_a ^ op_b;
        ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: ex.value = sh_result;
        ALU_ADC, ALU_SBC, ALU_NEG: ex.value = sum[31:0];
        ALU_CMP, ALU_CMN: begin
          ex.value = sum[31:0];
          ex.write = 1'b0;
        end
        ALU_ORR: ex.value = op_a | op_b;
        ALU_MUL: ex.value = mul_result;
        ALU_BIC: ex.value = op_a & ~op_b;
        default: ex.value = ~op_b;
      endcase
      case (op)
        ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
          ex.flags = {sh_result[31], (sh_result == 32'd0), sh_cout, flags_in[0]};
        end
        ALU_ADC, ALU_SBC, ALU_NEG, ALU_CMP, ALU_CMN: ex.flags = add_flags;
        default: ex.flags = nz_flags(ex.value, flags_in);
      endcase
    end else begin
      ex.unsup = 1'b1;
    end
  end

endmodule

`default_nettype wire

[src/thumb_data_processing_execute.sv]
`default_nettype none

// Thumb data-processing execute unit. Each word on the input channel is one
// 16-bit Thumb instruction; the block executes shift-by-immediate, three-operand
// add/subtract, 8-bit immediate MOV/CMP/ADD/SUB and the sixteen register ALU
// operations (MUL included) against its own eight low registers and NZCV flags,
// both cleared by reset. Every instruction yields exactly one output word with
// the computed value, the destination register, a write flag and the flags after
// the instruction. Any other encoding is reported as unsupported, with value and
// destination zero and the flags unchanged, and leaves the state untouched.
// Throughput is one instruction per clock while the receiver keeps up. At the
// accepting edge the word is captured together with its register-file operands;
// the execute logic works on them, and the output register is loaded as the
// execute stage advances. With the receiver stalled the block holds two words,
// one in execute and one in the output register, and then drops in_ready. The
// register file write-through lets the next instruction pick up the previous
// result in the same cycle, so dependent instructions also run back to back.
// The longest path is the 32x32 multiplier feeding the output register.

module thumb_data_processing_execute
  import tdpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] instruction,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] result_value,
  output logic      [2:0]  dest_index,
  output logic             reg_written,
  output logic      [3:0]  flags_nzcv,
  output logic             unsupported
);

  logic        in_accept;
  logic        advance;
  logic        ex_valid;
  logic [15:0] ex_instr;
  logic [3:0]  flags;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [2:0]  raddr_a;
  logic [2:0]  raddr_b;
  tdpe_exec_t  ex;

  // The execute stage moves on whenever the output register is free or drained.
  assign advance   = ex_valid && (!out_valid || out_ready);
  assign in_ready  = !ex_valid || advance;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_accept) begin
      ex_valid <= 1'b1;
    end else if (advance) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_instr <= instruction;
    end
  end

  // Operand addresses: port A carries Rs for the shift/add format, Rd for the
  // immediate format and Rd for the register ALU format; port B carries the
  // second register of the three-operand add/sub or Rs of the ALU format.
  always_comb begin
    if (instruction[15:13] == FMT_SHIFT_ADDSUB) begin
      raddr_a = instruction[5:3];
      raddr_b = instruction[8:6];
    end else if (instruction[15:13] == FMT_IMM8) begin
      raddr_a = instruction[10:8];
      raddr_b = instruction[5:3];
    end else begin
      raddr_a = instruction[2:0];
      raddr_b = instruction[5:3];
    end
  end

  tdpe_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (in_accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (op_a),
    .rdata_b (op_b),
    .we      (advance && ex.write && !ex.unsup),
    .waddr   (ex.dest),
    .wdata   (ex.value)
  );

  tdpe_alu u_alu (
    .instr    (ex_instr),
    .op_a     (op_a),
    .op_b     (op_b),
    .flags_in (flags),
    .ex       (ex)
  );

  // Flags are updated as the instruction leaves execute, so the next one
  // in the operand register always sees them current.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance && !ex.unsup) begin
      flags <= ex.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= ex.value;
      dest_index   <= ex.dest;
      reg_written  <= ex.write;
      flags_nzcv   <= ex.flags;
      unsupported  <= ex.unsup;
    end
  end

endmodule

`default_nettype wire
